@@ hw/rtl/gbe_pkg.sv @@
// ============================================================================
// gbe_pkg
// Shared types, constants and helpers for the glyph bitmap expander.
// ============================================================================
package gbe_pkg;

    // Glyph size limits
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    // Counter and size widths
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_SIZE_W = 7;
    localparam int SIZE_A     = (COL_W + 1 > ROW_W + 1) ? COL_W + 1 : ROW_W + 1;
    localparam int SIZE_W     = (SIZE_A > CFG_SIZE_W) ? SIZE_A : CFG_SIZE_W;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int PIX_W      = 32;
    localparam int COORD_W    = 7;
    localparam int OPAC_W     = 5;
    localparam int ALPHA_W    = 4;
    localparam int PIDX_W     = 3;

    // Configuration port
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;

    // Register reset values
    localparam logic [PIX_W-1:0]      FORE_RST    = 32'h0000_FFFF;
    localparam logic [PIX_W-1:0]      BACK_RST    = 32'h0000_0000;
    localparam logic [OPAC_W-1:0]     OPAC_RST    = 5'd16;
    localparam logic [CFG_SIZE_W-1:0] SIZE_RST    = 7'd16;
    localparam logic [OPAC_W-1:0]     OPAC_FULL   = 5'd16;
    localparam logic [PIX_W-1:0]      MASK_16BIT  = 32'h0000_FFFF;

    // Last pixel index within one byte
    localparam logic [PIDX_W-1:0]     LAST_MONO   = 3'd7;
    localparam logic [PIDX_W-1:0]     LAST_SMOOTH = 3'd1;

    // Register map (word index)
    typedef enum logic [2:0] {
        REG_SMOOTH  = 3'd0,
        REG_FORE    = 3'd1,
        REG_BACK    = 3'd2,
        REG_OPACITY = 3'd3,
        REG_DOUBLE  = 3'd4,
        REG_WIDTH   = 3'd5,
        REG_HEIGHT  = 3'd6,
        REG_PIX16   = 3'd7
    } reg_idx_t;

    // Quad position when doubling
    typedef enum logic [1:0] {
        QUAD_TL = 2'd0,
        QUAD_TR = 2'd1,
        QUAD_BL = 2'd2,
        QUAD_BR = 2'd3
    } quad_t;

    // Configuration register set
    typedef struct packed {
        logic                  smooth_mode;
        logic [PIX_W-1:0]      fore_color;
        logic [PIX_W-1:0]      back_color;
        logic [OPAC_W-1:0]     opacity_level;
        logic                  double_enable;
        logic [CFG_SIZE_W-1:0] glyph_width;
        logic [CFG_SIZE_W-1:0] glyph_height;
        logic                  pixel_16bit;
    } cfg_t;

    // Queue entry: one classified byte
    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              smooth;
        logic [PIDX_W-1:0] last_pix;
    } entry_t;

    // Saturate a size register to 1..maxv
    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [CFG_SIZE_W-1:0] v,
        input logic [SIZE_W-1:0]     maxv
    );
        logic [SIZE_W-1:0] r;
        r = SIZE_W'(v);
        if (v == '0)
            r = SIZE_W'(1);
        else if (r > maxv)
            r = maxv;
        return r;
    endfunction

endpackage

@@ hw/rtl/gbe_byte_if.sv @@
// ============================================================================
// gbe_byte_if
// Input channel: one packed glyph byte per transaction.
// ============================================================================
interface gbe_byte_if;
    logic                      valid;
    logic                      ready;
    logic [gbe_pkg::BYTE_W-1:0] packed_byte;

    modport source (output valid, output packed_byte, input ready);
    modport sink   (input valid, input packed_byte, output ready);
endinterface

@@ hw/rtl/gbe_pix_if.sv @@
// ============================================================================
// gbe_pix_if
// Output channel: one expanded pixel per transaction.
// ============================================================================
interface gbe_pix_if;
    logic                        valid;
    logic                        ready;
    logic [gbe_pkg::PIX_W-1:0]   pixel_value;
    logic [gbe_pkg::COORD_W-1:0] pixel_x;
    logic [gbe_pkg::COORD_W-1:0] pixel_y;
    logic                        glyph_done;
    logic                        run_last;

    modport source (output valid, output pixel_value, output pixel_x, output pixel_y,
                    output glyph_done, output run_last, input ready);
    modport sink   (input valid, input pixel_value, input pixel_x, input pixel_y,
                    input glyph_done, input run_last, output ready);
endinterface

@@ hw/rtl/glyph_bitmap_expander.sv @@
// ============================================================================
// glyph_bitmap_expander
// Expands packed glyph bytes into positioned pixels, mono or smooth,
// with optional 2x2 pixel doubling.
// ============================================================================
// The block delivers one pixel transaction per clock on the output channel
// while the output is ready and a byte is in hand. A mono byte gives 8 pixels,
// a smooth byte 2 pixels; with doubling every pixel becomes 4 transactions. A
// smooth byte at opacity zero gives no output but still advances the position.
// A byte that ends the glyph stops at the glyph's last pixel. The output walker
// and its single output register set the rate; a two-entry input queue lets
// the next bytes be taken while a byte is being expanded and while a finished
// pixel waits on the output.
module glyph_bitmap_expander (
    input  logic                         clk,
    input  logic                         rst_n,
    gbe_byte_if.sink                     in_ch,
    gbe_pix_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbe_pkg::APB_AW-1:0]   paddr,
    input  logic [gbe_pkg::APB_DW-1:0]   pwdata,
    output logic [gbe_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    gbe_pkg::cfg_t   cfg;
    logic            q_valid;
    logic            q_pop;
    gbe_pkg::entry_t q_entry;

    assign pready = 1'b1;

    // Configuration registers
    gbe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Input side and queue
    gbe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .smooth_mode (cfg.smooth_mode),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop)
    );

    // Pixel walker and output
    gbe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

@@ hw/rtl/gbe_regs.sv @@
// ============================================================================
// gbe_regs
// APB-style configuration register file.
// ============================================================================
module gbe_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbe_pkg::APB_AW-1:0]   paddr,
    input  logic [gbe_pkg::APB_DW-1:0]   pwdata,
    output logic [gbe_pkg::APB_DW-1:0]   prdata,
    output gbe_pkg::cfg_t                cfg
);

    gbe_pkg::cfg_t     cfg_reg;
    gbe_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx   = gbe_pkg::reg_idx_t'(paddr[gbe_pkg::APB_AW-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smooth_mode   <= 1'b0;
            cfg_reg.fore_color    <= gbe_pkg::FORE_RST;
            cfg_reg.back_color    <= gbe_pkg::BACK_RST;
            cfg_reg.opacity_level <= gbe_pkg::OPAC_RST;
            cfg_reg.double_enable <= 1'b0;
            cfg_reg.glyph_width   <= gbe_pkg::SIZE_RST;
            cfg_reg.glyph_height  <= gbe_pkg::SIZE_RST;
            cfg_reg.pixel_16bit   <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                gbe_pkg::REG_SMOOTH:  cfg_reg.smooth_mode   <= pwdata[0];
                gbe_pkg::REG_FORE:    cfg_reg.fore_color    <= pwdata;
                gbe_pkg::REG_BACK:    cfg_reg.back_color    <= pwdata;
                gbe_pkg::REG_OPACITY: cfg_reg.opacity_level <= pwdata[gbe_pkg::OPAC_W-1:0];
                gbe_pkg::REG_DOUBLE:  cfg_reg.double_enable <= pwdata[0];
                gbe_pkg::REG_WIDTH:   cfg_reg.glyph_width   <= pwdata[gbe_pkg::CFG_SIZE_W-1:0];
                gbe_pkg::REG_HEIGHT:  cfg_reg.glyph_height  <= pwdata[gbe_pkg::CFG_SIZE_W-1:0];
                gbe_pkg::REG_PIX16:   cfg_reg.pixel_16bit   <= pwdata[0];
                default:              cfg_reg.smooth_mode   <= cfg_reg.smooth_mode;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            gbe_pkg::REG_SMOOTH:  prdata = gbe_pkg::APB_DW'(cfg_reg.smooth_mode);
            gbe_pkg::REG_FORE:    prdata = cfg_reg.fore_color;
            gbe_pkg::REG_BACK:    prdata = cfg_reg.back_color;
            gbe_pkg::REG_OPACITY: prdata = gbe_pkg::APB_DW'(cfg_reg.opacity_level);
            gbe_pkg::REG_DOUBLE:  prdata = gbe_pkg::APB_DW'(cfg_reg.double_enable);
            gbe_pkg::REG_WIDTH:   prdata = gbe_pkg::APB_DW'(cfg_reg.glyph_width);
            gbe_pkg::REG_HEIGHT:  prdata = gbe_pkg::APB_DW'(cfg_reg.glyph_height);
            gbe_pkg::REG_PIX16:   prdata = gbe_pkg::APB_DW'(cfg_reg.pixel_16bit);
            default:              prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/gbe_front.sv @@
// ============================================================================
// gbe_front
// Accepts packed bytes, tags them with mode and last pixel index, queues them.
// ============================================================================
module gbe_front (
    input  logic                  clk,
    input  logic                  rst_n,
    gbe_byte_if.sink              in_ch,
    input  logic                  smooth_mode,
    output logic                  q_valid,
    output gbe_pkg::entry_t       q_entry,
    input  logic                  q_pop
);

    localparam int DEPTH = 2;

    gbe_pkg::entry_t  mem_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    gbe_pkg::entry_t  new_entry;

    // Classify the incoming byte
    always_comb
    begin
        new_entry.packed_byte = in_ch.packed_byte;
        new_entry.smooth      = smooth_mode;
        new_entry.last_pix    = smooth_mode ? gbe_pkg::LAST_SMOOTH : gbe_pkg::LAST_MONO;
    end

    assign in_ch.ready = (count_reg != 2'(DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (count_reg != '0);
    assign q_entry     = mem_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= new_entry;
    end

endmodule

@@ hw/rtl/gbe_back.sv @@
// ============================================================================
// gbe_back
// Walks the pixels of each queued byte, tracks glyph position and drives the
// output register, one pixel (or quad corner) per cycle while output is ready.
// ============================================================================
module gbe_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gbe_pkg::cfg_t         cfg,
    input  logic                  q_valid,
    input  gbe_pkg::entry_t       q_entry,
    output logic                  q_pop,
    gbe_pix_if.source             out_ch
);

    localparam int XW = gbe_pkg::COL_W + gbe_pkg::COORD_W;
    localparam int YW = gbe_pkg::ROW_W + gbe_pkg::COORD_W;

    // Work registers
    logic                            busy_reg, busy_next;
    gbe_pkg::entry_t                 cur_reg, cur_next;
    logic [gbe_pkg::PIDX_W-1:0]      pix_reg, pix_next;
    gbe_pkg::quad_t                  quad_reg, quad_next;
    logic [gbe_pkg::COL_W-1:0]       col_reg, col_next;
    logic [gbe_pkg::ROW_W-1:0]       row_reg, row_next;

    // Output register
    logic                            ov_reg, ov_next;
    logic [gbe_pkg::PIX_W-1:0]       oval_reg, oval_next;
    logic [gbe_pkg::COORD_W-1:0]     ox_reg, ox_next;
    logic [gbe_pkg::COORD_W-1:0]     oy_reg, oy_next;
    logic                            odone_reg, odone_next;
    logic                            olast_reg, olast_next;

    logic [gbe_pkg::SIZE_W-1:0]      w, h;
    logic                            row_end, glyph_end;
    logic                            step, emit, quad_last, pix_last, finish;
    logic [gbe_pkg::ALPHA_W-1:0]     alpha;
    logic [2*gbe_pkg::ALPHA_W-1:0]   scaled;
    logic [gbe_pkg::PIX_W-1:0]       val;
    logic                            bit_v;
    logic [XW-1:0]                   x_w;
    logic [YW-1:0]                   y_w;

    // Position decode
    always_comb
    begin
        w = gbe_pkg::clamp_size(cfg.glyph_width,  gbe_pkg::SIZE_W'(gbe_pkg::MAX_WIDTH));
        h = gbe_pkg::clamp_size(cfg.glyph_height, gbe_pkg::SIZE_W'(gbe_pkg::MAX_HEIGHT));
        row_end   = (gbe_pkg::SIZE_W'(col_reg) + gbe_pkg::SIZE_W'(1)) >= w;
        glyph_end = row_end
                    && ((gbe_pkg::SIZE_W'(row_reg) + gbe_pkg::SIZE_W'(1)) >= h);
    end

    // Pixel value
    always_comb
    begin
        alpha  = (pix_reg == '0) ? cur_reg.packed_byte[7:4] : cur_reg.packed_byte[3:0];
        scaled = alpha * cfg.opacity_level[gbe_pkg::ALPHA_W-1:0];
        bit_v  = cur_reg.packed_byte[3'(gbe_pkg::LAST_MONO - pix_reg)];
        emit   = 1'b1;
        if (cur_reg.smooth)
        begin
            priority if (cfg.opacity_level == '0)
            begin
                emit = 1'b0;
                val  = '0;
            end
            else if (cfg.opacity_level < gbe_pkg::OPAC_FULL)
                val = gbe_pkg::PIX_W'(scaled[2*gbe_pkg::ALPHA_W-1:gbe_pkg::ALPHA_W]);
            else
                val = gbe_pkg::PIX_W'(alpha);
        end
        else
        begin
            val = bit_v ? cfg.fore_color : cfg.back_color;
            if (cfg.pixel_16bit)
                val = val & gbe_pkg::MASK_16BIT;
        end
    end

    // Coordinates, doubled with quad offset when doubling
    always_comb
    begin
        if (cfg.double_enable)
        begin
            x_w = (XW'(col_reg) << 1) | XW'(quad_reg[0]);
            y_w = (YW'(row_reg) << 1) | YW'(quad_reg[1]);
        end
        else
        begin
            x_w = XW'(col_reg);
            y_w = YW'(row_reg);
        end
    end

    // Sequencing
    always_comb
    begin
        step      = busy_reg && (!ov_reg || out_ch.ready);
        quad_last = !cfg.double_enable || !emit || (quad_reg == gbe_pkg::QUAD_BR);
        pix_last  = glyph_end || (pix_reg == cur_reg.last_pix);
        finish    = step && quad_last && pix_last;
        q_pop     = q_valid && (!busy_reg || finish);
    end

    // Next state of the walker
    always_comb
    begin
        busy_next = busy_reg;
        cur_next  = cur_reg;
        pix_next  = pix_reg;
        quad_next = quad_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (step)
        begin
            if (!quad_last)
                quad_next = gbe_pkg::quad_t'(quad_reg + 2'd1);
            else
            begin
                quad_next = gbe_pkg::QUAD_TL;
                pix_next  = pix_reg + 3'd1;
                priority if (glyph_end)
                begin
                    col_next = '0;
                    row_next = '0;
                end
                else if (row_end)
                begin
                    col_next = '0;
                    row_next = row_reg + gbe_pkg::ROW_W'(1);
                end
                else
                    col_next = col_reg + gbe_pkg::COL_W'(1);
            end
        end
        if (finish)
        begin
            busy_next = 1'b0;
            pix_next  = '0;
            quad_next = gbe_pkg::QUAD_TL;
        end
        if (q_pop)
        begin
            busy_next = 1'b1;
            cur_next  = q_entry;
            pix_next  = '0;
            quad_next = gbe_pkg::QUAD_TL;
        end
    end

    // Next state of the output register
    always_comb
    begin
        ov_next    = ov_reg && !out_ch.ready;
        oval_next  = oval_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        odone_next = odone_reg;
        olast_next = olast_reg;
        if (step && emit)
        begin
            ov_next    = 1'b1;
            oval_next  = val;
            ox_next    = x_w[gbe_pkg::COORD_W-1:0];
            oy_next    = y_w[gbe_pkg::COORD_W-1:0];
            odone_next = glyph_end && quad_last;
            olast_next = quad_last && pix_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pix_reg  <= '0;
            quad_reg <= gbe_pkg::QUAD_TL;
            col_reg  <= '0;
            row_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pix_reg  <= pix_next;
            quad_reg <= quad_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            ov_reg   <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        oval_reg  <= oval_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        odone_reg <= odone_next;
        olast_reg <= olast_next;
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.pixel_value = oval_reg;
    assign out_ch.pixel_x     = ox_reg;
    assign out_ch.pixel_y     = oy_reg;
    assign out_ch.glyph_done  = odone_reg;
    assign out_ch.run_last    = olast_reg;

    // The glyph's final pixel always closes its byte
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && odone_reg) |-> olast_reg)
        else $error("glyph_done without run_last");

    // Idle walker sits at the first pixel and quad
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (pix_reg == '0 && quad_reg == gbe_pkg::QUAD_TL))
        else $error("walker not cleared while idle");

    // Glyph end returns the position to the origin
    a_glyph_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (step && quad_last && glyph_end) |=> (col_reg == '0 && row_reg == '0))
        else $error("position not cleared at glyph end");

endmodule
